// ===== hw/rtl/oled_prcd_pkg.sv =====
// Shared types and constants for the OLED page RAM command decoder.
// Depends on nothing; the top level uses it by scoped names.
package oled_prcd_pkg;

   // Item kinds carried on the request channel.
   typedef enum logic [1:0] {
      KIND_CONTROL    = 2'd0,
      KIND_PAYLOAD    = 2'd1,
      KIND_PIXEL_READ = 2'd2
   } kind_type;

   // What the payload bytes of the current message mean.
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_DATA = 2'd1,
      MODE_CMD  = 2'd2
   } mode_type;

   // Message start bytes.
   localparam logic [7:0] START_DATA = 8'h40;
   localparam logic [7:0] START_CMD  = 8'h00;

   // High nibbles of the pointer commands.
   localparam logic [3:0] NIB_COL_LOW  = 4'h0;
   localparam logic [3:0] NIB_COL_HIGH = 4'h1;
   localparam logic [3:0] NIB_PAGE     = 4'hB;

   // Commands that are accepted and have no effect here.
   localparam logic [7:0] CMD_ADDR_MODE    = 8'h20;
   localparam logic [7:0] CMD_START_LINE   = 8'h40;
   localparam logic [7:0] CMD_SEG_REMAP    = 8'hA1;
   localparam logic [7:0] CMD_RESUME_RAM   = 8'hA4;
   localparam logic [7:0] CMD_ENTIRE_ON    = 8'hA5;
   localparam logic [7:0] CMD_COM_SCAN_DEC = 8'hC8;
   localparam logic [7:0] CMD_DISPLAY_OFF  = 8'hAE;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'hAF;

   // Commands that are followed by one argument byte.
   localparam logic [7:0] CMD_CONTRAST     = 8'h81;
   localparam logic [7:0] CMD_MUX_RATIO    = 8'hA8;
   localparam logic [7:0] CMD_DISP_OFFSET  = 8'hD3;
   localparam logic [7:0] CMD_CLOCK_DIV    = 8'hD5;
   localparam logic [7:0] CMD_PRECHARGE    = 8'hD9;
   localparam logic [7:0] CMD_COM_PINS     = 8'hDA;
   localparam logic [7:0] CMD_VCOMH        = 8'hDB;
   localparam logic [7:0] CMD_LOCK         = 8'hFD;

   // Number of column bits in the pointer (128 columns per page).
   localparam int COL_BITS = 7;

endpackage

// ===== hw/rtl/oled_prcd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the display RAM of the command decoder.
module oled_prcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no new read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/oled_page_ram_command_decoder.sv =====
// Top level of the OLED page RAM command decoder: bus decode and pixel reads.
// Depends on oled_prcd_pkg and oled_prcd_ram.

// One transaction per cycle is accepted while req_ready is high (not during
// clearing or a response stall), and each yields one response transaction.
// Bus bytes update the write pointer and message mode in registers and store
// data bytes into a 1024-byte display RAM in the cycle they are accepted; a
// pixel read addresses the RAM in its accept cycle and its bit is taken from
// the registered RAM output as the read stage moves into the response register.
// A pixel read sees every data byte accepted before it. After reset the RAM
// is cleared one byte per cycle, keeping req_ready low until all of it is clear.
module oled_page_ram_command_decoder #(
   parameter int RAM_BYTES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_bus_byte,
   input  logic [6:0] req_pixel_x,
   input  logic [5:0] req_pixel_y,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_pixel_on,
   output logic       rsp_unknown_command
);

   localparam int AW        = $clog2(RAM_BYTES);
   localparam int PAGE_BITS = AW - oled_prcd_pkg::COL_BITS;

   // Architectural bus state.
   logic [AW-1:0]              ptr_ff, ptr_in;
   oled_prcd_pkg::mode_type    mode_ff, mode_in;
   logic                       skip_ff, skip_in;

   // Clearing pass.
   logic                       clr_busy_ff;
   logic [AW-1:0]              clr_addr_ff;

   // Read stage and response register.
   logic                       s1_valid_ff;
   logic                       s1_read_ff;
   logic [2:0]                 s1_bit_ff;
   logic                       s1_unk_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_pixel_on_ff;
   logic                       rsp_unknown_command_ff;

   logic                       accept;
   logic                       s1_move;
   logic                       data_write;
   logic                       pixel_read;
   logic                       unk;
   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [7:0]                 ram_wr_data;
   logic [AW-1:0]              ram_rd_addr;
   logic [7:0]                 ram_rd_data;

   // Handshake: the read stage drains into the response register whenever
   // that register is empty or being taken.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clr_busy_ff && (!s1_valid_ff || s1_move);
   assign accept    = req_valid && req_ready;

   // Next message mode and argument skip.
   always_comb begin
      mode_in = mode_ff;
      skip_in = skip_ff;
      if (accept) begin
         case (req_kind)
            oled_prcd_pkg::KIND_CONTROL: begin
               skip_in = 1'b0;
               if (req_bus_byte == oled_prcd_pkg::START_DATA) begin
                  mode_in = oled_prcd_pkg::MODE_DATA;
               end else if (req_bus_byte == oled_prcd_pkg::START_CMD) begin
                  mode_in = oled_prcd_pkg::MODE_CMD;
               end else begin
                  mode_in = oled_prcd_pkg::MODE_IDLE;
               end
            end
            oled_prcd_pkg::KIND_PAYLOAD: begin
               if (mode_ff == oled_prcd_pkg::MODE_CMD) begin
                  if (skip_ff) begin
                     skip_in = 1'b0;
                  end else if (req_bus_byte inside {
                        oled_prcd_pkg::CMD_CONTRAST, oled_prcd_pkg::CMD_MUX_RATIO,
                        oled_prcd_pkg::CMD_DISP_OFFSET, oled_prcd_pkg::CMD_CLOCK_DIV,
                        oled_prcd_pkg::CMD_PRECHARGE, oled_prcd_pkg::CMD_COM_PINS,
                        oled_prcd_pkg::CMD_VCOMH, oled_prcd_pkg::CMD_LOCK}) begin
                     skip_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Command decode, pointer update and RAM access of the accepted transaction.
   always_comb begin
      ptr_in     = ptr_ff;
      unk        = 1'b0;
      data_write = 1'b0;
      pixel_read = 1'b0;
      if (accept) begin
         case (req_kind)
            oled_prcd_pkg::KIND_PAYLOAD: begin
               if (mode_ff == oled_prcd_pkg::MODE_DATA) begin
                  data_write = 1'b1;
                  ptr_in     = ptr_ff + AW'(1);
               end else if (mode_ff == oled_prcd_pkg::MODE_CMD && !skip_ff) begin
                  if (req_bus_byte[7:4] == oled_prcd_pkg::NIB_COL_LOW) begin
                     ptr_in[3:0] = req_bus_byte[3:0];
                  end else if (req_bus_byte[7:4] == oled_prcd_pkg::NIB_COL_HIGH) begin
                     ptr_in[6:4] = req_bus_byte[2:0];
                  end else if (req_bus_byte[7:4] == oled_prcd_pkg::NIB_PAGE) begin
                     ptr_in[AW-1:oled_prcd_pkg::COL_BITS] = req_bus_byte[PAGE_BITS-1:0];
                  end else if (!(req_bus_byte inside {
                        oled_prcd_pkg::CMD_ADDR_MODE, oled_prcd_pkg::CMD_START_LINE,
                        oled_prcd_pkg::CMD_SEG_REMAP, oled_prcd_pkg::CMD_RESUME_RAM,
                        oled_prcd_pkg::CMD_ENTIRE_ON, oled_prcd_pkg::CMD_COM_SCAN_DEC,
                        oled_prcd_pkg::CMD_DISPLAY_OFF, oled_prcd_pkg::CMD_DISPLAY_ON,
                        oled_prcd_pkg::CMD_CONTRAST, oled_prcd_pkg::CMD_MUX_RATIO,
                        oled_prcd_pkg::CMD_DISP_OFFSET, oled_prcd_pkg::CMD_CLOCK_DIV,
                        oled_prcd_pkg::CMD_PRECHARGE, oled_prcd_pkg::CMD_COM_PINS,
                        oled_prcd_pkg::CMD_VCOMH, oled_prcd_pkg::CMD_LOCK})) begin
                     unk = 1'b1;
                  end
               end
            end
            oled_prcd_pkg::KIND_PIXEL_READ: begin
               pixel_read = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Bus state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         mode_ff <= oled_prcd_pkg::MODE_IDLE;
         skip_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         mode_ff <= mode_in;
         skip_ff <= skip_in;
      end
   end

   // Clearing pass through the display RAM after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(RAM_BYTES - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // RAM port selection; a pixel address is page (row / 8) then column.
   assign ram_wr_en   = clr_busy_ff || data_write;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : ptr_ff;
   assign ram_wr_data = clr_busy_ff ? 8'h00 : req_bus_byte;
   assign ram_rd_addr = {req_pixel_y[5:3], req_pixel_x};

   oled_prcd_ram #(
      .WIDTH (8),
      .DEPTH (RAM_BYTES)
   ) u_display_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (pixel_read),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Read stage: waits for the RAM data of a pixel read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_ff <= pixel_read;
         s1_bit_ff  <= req_pixel_y[2:0];
         s1_unk_ff  <= unk;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_pixel_on_ff        <= s1_read_ff & ram_rd_data[s1_bit_ff];
         rsp_unknown_command_ff <= s1_unk_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pixel_on        = rsp_pixel_on_ff;
   assign rsp_unknown_command = rsp_unknown_command_ff;

endmodule
